@@ rtl/core/bse_pkg.sv @@
// Shared types and constants for the battery state-of-charge estimator.
// No dependencies; imported by bse_ctrl, bse_datapath and the top level.
package bse_pkg;

    // Field widths
    localparam int ADC_W    = 12;
    localparam int MV_W     = 15;
    localparam int SOC_W    = 7;
    localparam int VREF_W   = 12;
    localparam int DIVR_W   = 4;
    localparam int OFFS_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int PROD_W   = ADC_W + VREF_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VREF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

    // Configuration reset values
    localparam logic [VREF_W-1:0] VREF_RST   = 12'd1400;
    localparam logic [DIVR_W-1:0] DIVR_RST   = 4'd3;
    localparam logic [OFFS_W-1:0] OFFSET_RST = 8'd70;

    // ADC full-scale code and sample ceiling
    localparam logic [ADC_W:0]  ADC_FULL   = 13'd4095;
    localparam logic [MV_W-1:0] SAMPLE_MAX = 15'd32767;

    // State-of-charge threshold table, ascending, in mV
    localparam int TABLE_SIZE = 21;
    localparam int THR_W      = 13;
    localparam logic [THR_W-1:0] SOC_THRESH [TABLE_SIZE] = '{
        13'd3000, 13'd3350, 13'd3410, 13'd3456, 13'd3495, 13'd3521, 13'd3543,
        13'd3561, 13'd3581, 13'd3602, 13'd3626, 13'd3656, 13'd3696, 13'd3744,
        13'd3794, 13'd3845, 13'd3903, 13'd3962, 13'd4020, 13'd4096, 13'd4200
    };
    localparam logic [SOC_W-1:0] SOC_STEP = 7'd5;
    localparam logic [SOC_W-1:0] SOC_MAX  = 7'd100;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch input beat
        logic mul;       // vref * adc
        logic quot;      // divide product by full scale
        logic scale;     // divider ratio, saturation, charge offset
        logic acc;       // window update, divider setup
        logic div_step;  // one quotient bit
        logic look;      // threshold lookup
        logic load_out;  // fill output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;  // final quotient bit this cycle
    } status_t;

endpackage

@@ rtl/core/battery_soc_estimator_unit.sv @@
// Battery state-of-charge estimator, top level.
// Each input beat is captured, multiplied, divided by full scale, scaled, written to the
// window, averaged by a divider that produces one quotient bit per cycle, looked up and
// loaded into the output register. A new beat is accepted only once the last is loaded; a result
// waiting in the output register holds the next item in its last step, stalling input.
// Reset (aresetn, synchronous): window empty, config registers to defaults.
// Depends on bse_pkg, bse_ctrl and bse_datapath.
module battery_soc_estimator_unit #(
    parameter int WINDOW_LEN = 8,
    parameter int SOC_LEVELS = 21
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration writes
    input  logic                               cfg_we,
    input  logic [bse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,  // [11:0] adc_code, [15:12] zero
    input  logic                               s_tuser,  // [0] charging
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata   // [14:0] sample_mv,
                                                         // [29:15] average_mv,
                                                         // [36:30] soc_percent,
                                                         // [39:37] zero
);
    import bse_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic [MV_W-1:0]  sample_mv;
    logic [MV_W-1:0]  average_mv;
    logic [SOC_W-1:0] soc_percent;

    bse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bse_datapath #(
        .WINDOW_LEN (WINDOW_LEN),
        .SOC_LEVELS (SOC_LEVELS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_adc          (s_tdata[ADC_W-1:0]),
        .in_charging     (s_tuser),
        .cmd             (cmd),
        .status          (status),
        .out_sample_mv   (sample_mv),
        .out_average_mv  (average_mv),
        .out_soc_percent (soc_percent)
    );

    assign m_tdata = {3'b000, soc_percent, average_mv, sample_mv};

endmodule

@@ rtl/core/bse_ctrl.sv @@
// Sequencer for the estimator: handshakes and step commands.
// Depends on bse_pkg (cmd_t, status_t).
module bse_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  bse_pkg::status_t status,
    output bse_pkg::cmd_t    cmd
);
    import bse_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_QUOT  = 8'b0000_0100,
        S_SCALE = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_LOOK  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_QUOT;
            end
            S_QUOT: begin
                cmd.quot   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/core/bse_datapath.sv @@
// Datapath: config registers, scaling, window memory, running sum, serial divider, lookup,
// output register. Depends on bse_pkg; driven by bse_ctrl commands.
module bse_datapath #(
    parameter int WINDOW_LEN = 8,
    parameter int SOC_LEVELS = 21
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bse_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [bse_pkg::ADC_W-1:0]           in_adc,
    input  logic                                in_charging,
    input  bse_pkg::cmd_t                       cmd,
    output bse_pkg::status_t                    status,
    output logic [bse_pkg::MV_W-1:0]            out_sample_mv,
    output logic [bse_pkg::MV_W-1:0]            out_average_mv,
    output logic [bse_pkg::SOC_W-1:0]           out_soc_percent
);
    import bse_pkg::*;

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = MV_W + $clog2(WINDOW_LEN);
    localparam int STEP_W = $clog2(SUM_W);
    localparam int SCAN_N = (SOC_LEVELS > TABLE_SIZE) ? TABLE_SIZE : SOC_LEVELS;
    localparam int SCAN_W = $clog2(TABLE_SIZE + 1);

    // Configuration registers
    logic [VREF_W-1:0] vref_reg;
    logic [DIVR_W-1:0] divr_reg;
    logic [OFFS_W-1:0] offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_reg   <= VREF_RST;
            divr_reg   <= DIVR_RST;
            offset_reg <= OFFSET_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_VREF:   vref_reg   <= cfg_wdata[VREF_W-1:0];
                REG_DIVR:   divr_reg   <= cfg_wdata[DIVR_W-1:0];
                REG_OFFSET: offset_reg <= cfg_wdata[OFFS_W-1:0];
                default:    ;
            endcase
        end
    end

    // Input capture and product
    logic [ADC_W-1:0]  adc_reg;
    logic              chg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ADC_W-1:0]  quo_reg;
    logic [MV_W-1:0]   mv_reg;

    // Product / 4095: estimate from the top bits, one correction step
    logic [ADC_W-1:0] quo_est;
    logic [ADC_W:0]   quo_rem;
    logic [ADC_W-1:0] quo_next;

    assign quo_est  = prod_reg[PROD_W-1:ADC_W];
    assign quo_rem  = {1'b0, prod_reg[ADC_W-1:0]} + {1'b0, quo_est};
    assign quo_next = (quo_rem >= ADC_FULL) ? quo_est + 1'b1 : quo_est;

    // Divider ratio, saturation and charging correction
    logic [ADC_W+DIVR_W-1:0] scaled;
    logic [MV_W-1:0]         sat_mv;
    logic [MV_W-1:0]         mv_next;

    assign scaled = quo_reg * divr_reg;
    assign sat_mv = (scaled > {{(ADC_W+DIVR_W-MV_W){1'b0}}, SAMPLE_MAX})
                    ? SAMPLE_MAX : scaled[MV_W-1:0];

    always_comb begin
        mv_next = sat_mv;
        if (chg_reg) begin
            mv_next = (sat_mv > {{(MV_W-OFFS_W){1'b0}}, offset_reg})
                      ? sat_mv - {{(MV_W-OFFS_W){1'b0}}, offset_reg} : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            adc_reg <= in_adc;
            chg_reg <= in_charging;
        end
        if (cmd.mul) begin
            prod_reg <= vref_reg * adc_reg;
        end
        if (cmd.quot) begin
            quo_reg <= quo_next;
        end
        if (cmd.scale) begin
            mv_reg <= mv_next;
        end
    end

    // Sample window memory; read of the current slot is always registered
    logic [MV_W-1:0]   win_mem [WINDOW_LEN];
    logic [MV_W-1:0]   old_reg;
    logic [SLOT_W-1:0] slot_reg;

    always_ff @(posedge aclk) begin
        old_reg <= win_mem[slot_reg];
        if (cmd.acc) begin
            win_mem[slot_reg] <= mv_reg;
        end
    end

    // Running sum, fill count and write slot
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              full;

    assign full     = (cnt_reg == CNT_W'(WINDOW_LEN));
    assign sum_next = full ? sum_reg - {{(SUM_W-MV_W){1'b0}}, old_reg}
                                     + {{(SUM_W-MV_W){1'b0}}, mv_reg}
                           : sum_reg + {{(SUM_W-MV_W){1'b0}}, mv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            slot_reg <= '0;
        end else if (cmd.acc) begin
            sum_reg  <= sum_next;
            if (!full) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            slot_reg <= (slot_reg == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;
        end
    end

    // Restoring divider: sum / count, one quotient bit per cycle
    logic [SUM_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign shifted = {rem_reg, dvd_reg[SUM_W-1]};
    assign ge      = (shifted >= {1'b0, cnt_reg});
    assign diff    = shifted - {1'b0, cnt_reg};

    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            dvd_reg  <= sum_next;
            rem_reg  <= '0;
            step_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg  <= {dvd_reg[SUM_W-2:0], ge};
            rem_reg  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            step_reg <= step_reg + 1'b1;
        end
    end

    assign status.div_last = (step_reg == STEP_W'(SUM_W - 1));

    // Threshold lookup: table is ascending, so the index is the count
    // of thresholds below the average
    logic [MV_W-1:0]       avg;
    logic [TABLE_SIZE-1:0] above;
    logic [SCAN_W-1:0]     n_above;
    logic [SCAN_W-1:0]     soc_idx;
    logic [SOC_W-1:0]      pct;
    logic [SOC_W-1:0]      soc_reg;
    logic [MV_W-1:0]       avg_reg;

    assign avg = dvd_reg[MV_W-1:0];

    always_comb begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            above[i] = (i < SCAN_N) && (avg > {{(MV_W-THR_W){1'b0}}, SOC_THRESH[i]});
        end
    end

    assign n_above = SCAN_W'($countones(above));
    assign soc_idx = (n_above >= SCAN_W'(SCAN_N)) ? SCAN_W'(SCAN_N - 1) : n_above;
    assign pct     = SOC_W'(soc_idx * SOC_STEP);

    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            avg_reg <= avg;
            soc_reg <= (pct > SOC_MAX) ? SOC_MAX : pct;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_sample_mv   <= mv_reg;
            out_average_mv  <= avg_reg;
            out_soc_percent <= soc_reg;
        end
    end

endmodule

@@ tb/sv/bse_soc_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for battery_soc_estimator_unit: mirrors config writes, predicts each result beat
// from the accepted input beats and compares it field by field. Depends on bse_pkg.
module bse_soc_checker #(
    parameter int WINDOW_LEN = 8,
    parameter int SOC_LEVELS = 21
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [bse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [15:0]                        s_tdata,
    input  logic                               s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [39:0]                        m_tdata,
    output int                                 mismatch_count,
    output int                                 readings_pending
);

    localparam int NUM_THRESH = 21;
    localparam int unsigned MV_CEIL = 32767;

    typedef struct packed {
        logic [6:0]  soc_percent;
        logic [14:0] average_mv;
        logic [14:0] sample_mv;
    } soc_reading_t;

    // Discharge curve, ascending, in mV
    int unsigned thresh_mv [NUM_THRESH] = '{
        3000, 3350, 3410, 3456, 3495, 3521, 3543, 3561, 3581, 3602, 3626,
        3656, 3696, 3744, 3794, 3845, 3903, 3962, 4020, 4096, 4200
    };

    // Register copies
    logic [bse_pkg::VREF_W-1:0] vref_q;
    logic [bse_pkg::DIVR_W-1:0] div_q;
    logic [bse_pkg::OFFS_W-1:0] off_q;

    // Averaging window copy
    int unsigned window_mv [WINDOW_LEN];
    int unsigned next_slot;
    int unsigned fill_level;
    int unsigned window_sum;

    soc_reading_t expected_readings [$];
    int unsigned  result_idx;

    // First threshold at or above the average picks the 5% step
    function automatic logic [6:0] soc_from_avg(int unsigned avg);
        int unsigned levels;
        int unsigned idx;
        int unsigned pct;
        levels = (SOC_LEVELS > NUM_THRESH) ? NUM_THRESH : ((SOC_LEVELS < 1) ? 1 : SOC_LEVELS);
        idx = 0;
        while (idx < levels && avg > thresh_mv[idx]) idx++;
        if (idx >= levels) idx = levels - 1;
        pct = idx * 5;
        if (pct > 100) pct = 100;
        return pct[6:0];
    endfunction

    // Scale, correct for charging, then push through the window
    function automatic soc_reading_t predict_reading(logic [11:0] adc, logic chg);
        int unsigned mv;
        int unsigned avg;
        soc_reading_t r;
        mv = (32'(vref_q) * 32'(adc)) / 32'd4095;
        mv = mv * 32'(div_q);
        if (mv > MV_CEIL) mv = MV_CEIL;
        if (chg) mv = (mv > 32'(off_q)) ? mv - 32'(off_q) : 0;

        if (fill_level >= WINDOW_LEN) begin
            window_sum = window_sum - window_mv[next_slot] + mv;
        end else begin
            window_sum = window_sum + mv;
            fill_level = fill_level + 1;
        end
        window_mv[next_slot] = mv;
        next_slot = (next_slot + 1) % WINDOW_LEN;

        avg = window_sum / fill_level;
        if (avg > MV_CEIL) avg = MV_CEIL;

        r.sample_mv   = mv[14:0];
        r.average_mv  = avg[14:0];
        r.soc_percent = soc_from_avg(avg);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        soc_reading_t got;
        soc_reading_t want;
        if (!aresetn) begin
            vref_q     = bse_pkg::VREF_RST;
            div_q      = bse_pkg::DIVR_RST;
            off_q      = bse_pkg::OFFSET_RST;
            next_slot  = 0;
            fill_level = 0;
            window_sum = 0;
            for (int i = 0; i < WINDOW_LEN; i++) window_mv[i] = 0;
            expected_readings.delete();
            result_idx       = 0;
            mismatch_count   = 0;
            readings_pending = 0;
        end else begin
            // Register writes; unknown index is dropped
            if (cfg_we) begin
                case (cfg_index)
                    bse_pkg::REG_VREF:   vref_q = cfg_wdata[bse_pkg::VREF_W-1:0];
                    bse_pkg::REG_DIVR:   div_q  = cfg_wdata[bse_pkg::DIVR_W-1:0];
                    bse_pkg::REG_OFFSET: off_q  = cfg_wdata[bse_pkg::OFFS_W-1:0];
                    default: ;
                endcase
            end

            // Input beat
            if (s_tvalid && s_tready)
                expected_readings.push_back(predict_reading(s_tdata[11:0], s_tuser));

            // Result beat
            if (m_tvalid && m_tready) begin
                got.sample_mv   = m_tdata[14:0];
                got.average_mv  = m_tdata[29:15];
                got.soc_percent = m_tdata[36:30];
                if (expected_readings.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] result %0d: unexpected beat, sample %0d avg %0d soc %0d",
                                 $realtime, result_idx, got.sample_mv, got.average_mv,
                                 got.soc_percent);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.sample_mv !== want.sample_mv || got.average_mv !== want.average_mv ||
                        got.soc_percent !== want.soc_percent) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("[%0t] result %0d mismatch: sample exp %0d got %0d, ",
                                   $realtime, result_idx, want.sample_mv, got.sample_mv);
                            $display("avg exp %0d got %0d, soc exp %0d got %0d",
                                     want.average_mv, got.average_mv,
                                     want.soc_percent, got.soc_percent);
                        end
                    end
                end
                result_idx++;
            end
            readings_pending = expected_readings.size();
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the battery_soc_estimator_unit testbench: clock, reset, config writes and beat traffic.
// Depends on bse_pkg, the unit itself and bse_soc_checker, which does all result checking.
module tb_top;

    localparam int WINDOW_LEN    = 8;
    localparam int SOC_LEVELS    = 21;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 500;   // long receiver hold-off
    // Worst honest gap between beats: hold-off plus latency plus a long random stall
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 250;
    localparam logic [bse_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bse_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [11:0] adc_code, [15:12] zero
    logic        s_tuser;   // [0] charging
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [14:0] sample_mv, [29:15] average_mv, [36:30] soc_percent

    int          mismatch_count;
    int          readings_pending;

    // Traffic shaping, written by the stimulus process
    int          s_idle_pct;
    int          r_idle_pct;
    bit          hold_request;
    int unsigned cur_vref;
    int unsigned cur_div;
    int unsigned level_mv;

    always #5 aclk = ~aclk;

    battery_soc_estimator_unit #(
        .WINDOW_LEN (WINDOW_LEN),
        .SOC_LEVELS (SOC_LEVELS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bse_soc_checker #(
        .WINDOW_LEN (WINDOW_LEN),
        .SOC_LEVELS (SOC_LEVELS)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatch_count   (mismatch_count),
        .readings_pending (readings_pending)
    );

    // Offer one beat, with random idle cycles ahead of it; returns at the negedge after acceptance
    task automatic send_reading(logic [11:0] adc, logic chg);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, adc};
        s_tuser  <= chg;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [bse_pkg::CFG_IDX_W-1:0] idx, logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(logic [11:0] vref, logic [11:0] div, logic [11:0] off);
        write_reg(bse_pkg::REG_VREF, vref);
        write_reg(bse_pkg::REG_DIVR, div);
        write_reg(bse_pkg::REG_OFFSET, off);
        cur_vref = 32'(vref);
        cur_div  = 32'(div[3:0]);
    endtask

    // Drain all outstanding results, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (readings_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Mostly codes that land near a drifting battery level, some fully random
    task automatic send_random();
        int unsigned pick;
        int unsigned scale;
        int unsigned code;
        pick = $urandom_range(99);
        if (pick < 5) level_mv = $urandom_range(4400, 2800);
        else level_mv = level_mv + $urandom_range(80) - 40;
        if (level_mv < 2800) level_mv = 2800;
        if (level_mv > 4400) level_mv = 4400;
        scale = cur_vref * cur_div;
        if (pick >= 75 || scale == 0) begin
            code = $urandom_range(4095);
        end else begin
            code = (level_mv * 4095) / scale + $urandom_range(2);
            if (code > 4095) code = 4095;
        end
        send_reading(code[11:0], 1'($urandom_range(1)));
    endtask

    // Result side: random back-pressure plus one long hold-off on request
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= r_idle_pct);
            end
        end
    end

    // Ends the run when no beat moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_idle_pct   = 10;
        r_idle_pct   = 74;
        hold_request = 1'b0;
        cur_vref     = 1400;
        cur_div      = 3;
        level_mv     = 3600;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset defaults: zero code, offset above reading, full scale, exact first threshold,
        // then enough beats to wrap the window
        send_reading(12'd0, 1'b0);
        send_reading(12'd0, 1'b1);
        send_reading(12'd4095, 1'b0);
        send_reading(12'd4095, 1'b1);
        send_reading(12'd2925, 1'b0);
        send_reading(12'd2926, 1'b0);
        send_reading(12'd3500, 1'b1);
        send_reading(12'd3700, 1'b0);
        send_reading(12'd3900, 1'b0);
        send_reading(12'd4095, 1'b0);

        // Registers beyond range: scaled value saturates, average above every threshold
        settle();
        set_config(12'd4095, 12'd15, 12'd255);
        send_reading(12'd4095, 1'b0);
        send_reading(12'd4095, 1'b1);
        send_reading(12'd2048, 1'b0);
        send_reading(12'd4095, 1'b0);
        send_reading(12'd4095, 1'b0);

        // Divider of zero via masked write; unknown register index is ignored
        settle();
        write_reg(bse_pkg::REG_DIVR, 12'hFF0);
        write_reg(REG_UNUSED, 12'hABC);
        cur_div = 0;
        send_reading(12'd4095, 1'b1);
        send_reading(12'd1234, 1'b0);

        // Zero reference; upper write bits masked off
        settle();
        set_config(12'd0, 12'hFF8, 12'hF00);
        send_reading(12'd4095, 1'b0);

        // Top of the stated ranges, alternating code bits
        settle();
        set_config(12'd3600, 12'd8, 12'd255);
        send_reading(12'hAAA, 1'b1);
        send_reading(12'h555, 1'b0);
        send_reading(12'd4095, 1'b1);

        // Random phases: idle pattern changes every two phases
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: set_config(12'd1400, 12'd3, 12'd70);
                1: set_config(12'd3600, 12'd8, 12'd255);
                2: set_config(12'd3600, 12'd1, 12'd0);
                3: set_config(12'($urandom_range(3600)), 12'($urandom_range(8, 1)),
                              12'($urandom_range(255)));
                4: set_config(12'd4095, 12'd15, 12'($urandom_range(255)));
                default: set_config(12'd1400, 12'd3, 12'd70);
            endcase
            s_idle_pct = (ph < 2) ? 10 : ((ph < 4) ? 74 : 0);
            r_idle_pct = (ph < 2) ? 74 : ((ph < 4) ? 10 : 0);
            if (ph == 5) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) send_random();
        end

        settle();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
